// File: hw/rtl/idea_pkg.sv
// ----------------------------------------------------------------------------
// idea_pkg
// Shared types and arithmetic for the IDEA cipher pipeline: mod 65537
// multiply, additive inverse and subkey extraction from the 128-bit key.
// ----------------------------------------------------------------------------
`default_nettype none

package idea_pkg;

  // subkey index width, enough for the largest schedule of 52 subkeys
  localparam int unsigned SkIdxW = 6;

  // configuration register indexes
  localparam logic IdxKeyUpper = 1'b0;
  localparam logic IdxKeyLower = 1'b1;

  // control that travels with each request through the pipeline
  typedef struct packed {
    logic valid;
    logic op;     // 0 encrypt, 1 decrypt
  } pipe_ctl_t;

  // multiply mod 65537, a word of 0 stands for 65536
  function automatic logic [15:0] mul16(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] r;
    p  = a * b;
    lo = p[15:0];
    hi = p[31:16];
    if (a == 16'd0) begin
      r = 16'd1 - b;
    end else if (b == 16'd0) begin
      r = 16'd1 - a;
    end else begin
      r = lo - hi + {15'd0, (lo < hi)};
    end
    return r;
  endfunction

  // additive inverse mod 65536
  function automatic logic [15:0] neg16(input logic [15:0] a);
    return 16'd0 - a;
  endfunction

  // encryption subkey number idx: eight words per 25-bit left rotation
  function automatic logic [15:0] ek_word(input logic [127:0] key,
                                          input logic [SkIdxW-1:0] idx);
    logic [2:0]   grp;
    logic [2:0]   pos;
    logic [9:0]   prod;
    logic [6:0]   shamt;
    logic [255:0] dbl;
    logic [127:0] rot;
    grp   = idx[5:3];
    pos   = idx[2:0];
    prod  = {7'd0, grp} * 10'd25;
    shamt = prod[6:0];
    dbl   = {key, key} << shamt;
    rot   = dbl[255:128];
    return 16'(rot >> {(3'd7 - pos), 4'b0000});
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/idea_round.sv
// ----------------------------------------------------------------------------
// idea_round
// One IDEA round in three register stages: key mixing, first MA multiply,
// second MA multiply with the output mixing.
// ----------------------------------------------------------------------------
`default_nettype none

module idea_round (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire idea_pkg::pipe_ctl_t  ctl_i,
  input  wire logic [63:0]          blk_i,
  input  wire logic [5:0][15:0]     ek_i,
  input  wire logic [5:0][15:0]     dk_i,
  output idea_pkg::pipe_ctl_t       ctl_o,
  output logic [63:0]               blk_o
);

  idea_pkg::pipe_ctl_t ctl1_q, ctl2_q, ctl3_q;
  logic [15:0] a1_q, b1_q, c1_q, d1_q;
  logic [15:0] a2_q, c2_q, bd2_q, d2_q, b2_q, t02_q;
  logic [63:0] w3_q;
  logic [5:0][15:0] k1, k2, k3;
  logic [15:0] t1, t2;

  // subkey choice per stage by the request's operation
  assign k1 = ctl_i.op  ? dk_i : ek_i;
  assign k2 = ctl1_q.op ? dk_i : ek_i;
  assign k3 = ctl2_q.op ? dk_i : ek_i;

  // second multiply and output mixing
  assign t1 = idea_pkg::mul16(k3[5], t02_q + bd2_q);
  assign t2 = t02_q + t1;

  // valid and operation travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    a1_q  <= idea_pkg::mul16(blk_i[63:48], k1[0]);
    b1_q  <= blk_i[47:32] + k1[1];
    c1_q  <= blk_i[31:16] + k1[2];
    d1_q  <= idea_pkg::mul16(blk_i[15:0], k1[3]);

    a2_q  <= a1_q;
    b2_q  <= b1_q;
    c2_q  <= c1_q;
    d2_q  <= d1_q;
    bd2_q <= b1_q ^ d1_q;
    t02_q <= idea_pkg::mul16(k2[4], a1_q ^ c1_q);

    w3_q  <= {a2_q ^ t1, c2_q ^ t1, b2_q ^ t2, d2_q ^ t2};
  end

  assign ctl_o = ctl3_q;
  assign blk_o = w3_q;

endmodule

`default_nettype wire

// File: hw/rtl/idea_block_cipher.sv
// ----------------------------------------------------------------------------
// idea_block_cipher
// IDEA encrypt/decrypt of 64-bit blocks under a 128-bit key, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   The key is written through wr_en_i / wr_idx_i / wr_data_i (index 0 is the
//   upper 64 key bits, index 1 the lower). After reset and after each key
//   write the block derives the decryption subkeys with one shared mod 65537
//   multiplier and holds busy high meanwhile: 4*ROUNDS+2 direct subkeys (34 for
//   eight rounds) plus 2*(ROUNDS+1) inverses. Key writes are to be made only
//   while no request is in flight; the block itself does not enforce this.
//   A request is taken on a rising edge with start high and busy low, with
//   operation_i (0 encrypt, 1 decrypt) and block_in_i. One request may be
//   taken every cycle. Each round is three register stages (three dependent
//   multiplies per round set the split) and the output transform is one
//   more, and the result appears on block_out_o for one cycle with done_o
//   high. The receiver cannot stall.
//   Reset clears the key to zero and restarts the subkey derivation.
// ----------------------------------------------------------------------------
`default_nettype none

module idea_block_cipher #(
  parameter int unsigned ROUNDS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation_i,
  input  wire logic [63:0] block_in_i,
  output logic             done_o,
  output logic [63:0]      block_out_o,
  input  wire logic        wr_en_i,
  input  wire logic        wr_idx_i,
  input  wire logic [63:0] wr_data_i
);

  localparam int unsigned RowW = (ROUNDS + 1 > 1) ? $clog2(ROUNDS + 1) : 1;
  localparam logic [RowW-1:0] LastRow = RowW'(ROUNDS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_INV
  } seq_e;

  logic [63:0] key_upper_q, key_lower_q;
  logic [127:0] key;

  seq_e            state_q;
  logic [RowW-1:0] row_q;
  logic [2:0]      pos_q;
  logic [3:0]      cnt_q;
  logic            phase_q;
  logic [15:0]     res_q, base_q;

  logic [15:0] dk_q [ROUNDS+1][6];

  logic [2:0]                  src_pos;
  logic [idea_pkg::SkIdxW-1:0] src_idx;
  logic [15:0]                 src_word;
  logic [15:0]                 mul_out;
  logic                        last_pos;

  assign key  = {key_upper_q, key_lower_q};
  assign busy = (state_q != ST_IDLE);

  // source subkey for the decryption subkey at row_q, pos_q
  always_comb begin
    src_pos = pos_q;
    if ((pos_q == 3'd1 || pos_q == 3'd2) && row_q != '0 && row_q != LastRow) begin
      src_pos = 3'd3 - pos_q;
    end
    if (pos_q < 3'd4) begin
      src_idx = idea_pkg::SkIdxW'(6 * (int'(ROUNDS) - int'(row_q)) + int'(src_pos));
    end else begin
      src_idx = idea_pkg::SkIdxW'(6 * (int'(ROUNDS) - 1 - int'(row_q)) + int'(src_pos));
    end
  end

  assign src_word = idea_pkg::ek_word(key, src_idx);
  assign mul_out  = idea_pkg::mul16(phase_q ? base_q : res_q, base_q);
  assign last_pos = (row_q == LastRow) ? (pos_q == 3'd3) : (pos_q == 3'd5);

  // key registers and decryption subkey sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
      state_q     <= ST_STEP;
      row_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        idea_pkg::IdxKeyUpper: key_upper_q <= wr_data_i;
        idea_pkg::IdxKeyLower: key_lower_q <= wr_data_i;
        default: ;
      endcase
      state_q <= ST_STEP;
      row_q   <= '0;
      pos_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: ;
        ST_STEP: begin
          if (pos_q == 3'd0 || pos_q == 3'd3) begin
            cnt_q   <= '0;
            phase_q <= 1'b0;
            state_q <= ST_INV;
          end else if (last_pos) begin
            if (row_q == LastRow) begin
              state_q <= ST_IDLE;
            end else begin
              row_q <= row_q + 1'b1;
              pos_q <= '0;
            end
          end else begin
            pos_q <= pos_q + 3'd1;
          end
        end
        ST_INV: begin
          phase_q <= ~phase_q;
          if (phase_q) begin
            cnt_q <= cnt_q + 4'd1;
            if (cnt_q == 4'd15) begin
              if (last_pos) begin
                if (row_q == LastRow) begin
                  state_q <= ST_IDLE;
                end else begin
                  row_q   <= row_q + 1'b1;
                  pos_q   <= '0;
                  state_q <= ST_STEP;
                end
              end else begin
                pos_q   <= pos_q + 3'd1;
                state_q <= ST_STEP;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // inverse datapath and subkey store
  always_ff @(posedge clk_i) begin
    if (state_q == ST_STEP) begin
      base_q <= src_word;
      res_q  <= 16'd1;
      if (pos_q == 3'd1 || pos_q == 3'd2) begin
        dk_q[row_q][pos_q] <= idea_pkg::neg16(src_word);
      end else if (pos_q == 3'd4 || pos_q == 3'd5) begin
        dk_q[row_q][pos_q] <= src_word;
      end
    end else if (state_q == ST_INV) begin
      if (!phase_q) begin
        res_q <= mul_out;
      end else begin
        base_q <= mul_out;
        if (cnt_q == 4'd15) begin
          dk_q[row_q][pos_q] <= res_q;
        end
      end
    end
  end

  // round pipeline
  idea_pkg::pipe_ctl_t ctl [ROUNDS+1];
  logic [63:0]         blk [ROUNDS+1];

  assign ctl[0] = '{valid: start && !busy, op: operation_i};
  assign blk[0] = block_in_i;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    logic [5:0][15:0] ek, dk;
    for (genvar k = 0; k < 6; k++) begin : g_key
      assign ek[k] = idea_pkg::ek_word(key, idea_pkg::SkIdxW'(6 * r + k));
      assign dk[k] = dk_q[r][k];
    end
    idea_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[r]),
      .blk_i  (blk[r]),
      .ek_i   (ek),
      .dk_i   (dk),
      .ctl_o  (ctl[r+1]),
      .blk_o  (blk[r+1])
    );
  end

  // output transform
  logic [3:0][15:0] fk;
  logic [63:0]      w;
  logic             done_q;
  logic [63:0]      out_q;

  assign w = blk[ROUNDS];
  for (genvar k = 0; k < 4; k++) begin : g_fkey
    assign fk[k] = ctl[ROUNDS].op ? dk_q[ROUNDS][k]
                 : idea_pkg::ek_word(key, idea_pkg::SkIdxW'(6 * ROUNDS + k));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl[ROUNDS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= {idea_pkg::mul16(w[63:48], fk[0]), w[31:16] + fk[1],
              w[47:32] + fk[2], idea_pkg::mul16(w[15:0], fk[3])};
  end

  assign done_o      = done_q;
  assign block_out_o = out_q;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// IDEA block cipher testbench
// Drives encrypt and decrypt requests under several keys, predicts each
// result with a behavioral IDEA model and checks every returned block in
// order. Sender gaps are randomized in phases; key writes happen only idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  localparam int unsigned NumRounds = 8;
  localparam int unsigned NumSubkeys = 6 * NumRounds + 4;
  localparam int unsigned Latency = 3 * NumRounds + 1;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ExpDepth = 64;
  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        operation_i;
  logic [63:0] block_in_i;
  logic        done_o;
  logic [63:0] block_out_o;
  logic        wr_en_i;
  logic        wr_idx_i;
  logic [63:0] wr_data_i;

  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic [63:0] expected_blocks[ExpDepth];
  int unsigned send_gap_pct;
  int unsigned cycle_cnt;
  int unsigned fail_cnt;
  int unsigned block_cnt;
  int unsigned checked_cnt;

  idea_block_cipher #(.ROUNDS(NumRounds)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operation_i(operation_i),
    .block_in_i (block_in_i),
    .done_o     (done_o),
    .block_out_o(block_out_o),
    .wr_en_i    (wr_en_i),
    .wr_idx_i   (wr_idx_i),
    .wr_data_i  (wr_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // multiply mod 65537, zero word means 65536
  function automatic logic [15:0] mod_mul(input logic [15:0] a, input logic [15:0] b);
    logic [33:0] x;
    logic [33:0] y;
    x = (a == 16'd0) ? 34'h10000 : {18'd0, a};
    y = (b == 16'd0) ? 34'h10000 : {18'd0, b};
    return 16'((x * y) % 34'h10001);
  endfunction

  // inverse mod 65537 by exponent 65535
  function automatic logic [15:0] mod_inv(input logic [15:0] a);
    logic [15:0] acc;
    logic [15:0] base;
    acc = 16'd1;
    base = a;
    for (int i = 0; i < 16; i++) begin
      acc = mod_mul(acc, base);
      base = mod_mul(base, base);
    end
    return acc;
  endfunction

  function automatic void key_schedule(output logic [15:0] sk[NumSubkeys]);
    logic [127:0] k;
    k = {key_hi_q, key_lo_q};
    for (int i = 0; i < NumSubkeys; i++) begin
      sk[i] = k[127 - 16 * (i % 8) -: 16];
      if (i % 8 == 7) k = {k[102:0], k[127:103]};
    end
  endfunction

  function automatic void cipher_round(inout logic [15:0] w[4], input logic [15:0] k[6]);
    logic [15:0] a, b, c, d, t0, t1, t2;
    a = mod_mul(w[0], k[0]);
    b = w[1] + k[1];
    c = w[2] + k[2];
    d = mod_mul(w[3], k[3]);
    t0 = mod_mul(k[4], a ^ c);
    t1 = mod_mul(k[5], t0 + (b ^ d));
    t2 = t0 + t1;
    w[0] = a ^ t1;
    w[1] = c ^ t1;
    w[2] = b ^ t2;
    w[3] = d ^ t2;
  endfunction

  // expected output block for one request
  function automatic logic [63:0] idea_block(input logic op, input logic [63:0] blk);
    logic [15:0] sk[NumSubkeys];
    logic [15:0] w[4];
    logic [15:0] k[6];
    int s;
    key_schedule(sk);
    for (int i = 0; i < 4; i++) w[i] = blk[63 - 16 * i -: 16];
    for (int r = 0; r < NumRounds; r++) begin
      if (op == OpEncrypt) begin
        for (int j = 0; j < 6; j++) k[j] = sk[6 * r + j];
      end else begin
        s = 6 * (NumRounds - r);
        k[0] = mod_inv(sk[s]);
        k[1] = -sk[s + ((r == 0) ? 1 : 2)];
        k[2] = -sk[s + ((r == 0) ? 2 : 1)];
        k[3] = mod_inv(sk[s + 3]);
        k[4] = sk[6 * (NumRounds - 1 - r) + 4];
        k[5] = sk[6 * (NumRounds - 1 - r) + 5];
      end
      cipher_round(w, k);
    end
    if (op == OpEncrypt) begin
      for (int j = 0; j < 4; j++) k[j] = sk[6 * NumRounds + j];
    end else begin
      k[0] = mod_inv(sk[0]);
      k[1] = -sk[1];
      k[2] = -sk[2];
      k[3] = mod_inv(sk[3]);
    end
    return {mod_mul(w[0], k[0]), 16'(w[2] + k[1]), 16'(w[1] + k[2]), mod_mul(w[3], k[3])};
  endfunction

  // send one request, with a random gap before it; start stays high after
  task automatic send_block(input logic op, input logic [63:0] blk);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    block_in_i <= blk;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_blocks[block_cnt % ExpDepth] = idea_block(op, blk);
    block_cnt++;
  endtask

  // stop sending, wait until all results are back, then let the pipeline drain
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (block_cnt != checked_cnt) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // one register write; the caller drops the write enable
  task automatic write_key(input logic idx, input logic [63:0] val);
    wr_en_i <= 1'b1;
    wr_idx_i <= idx;
    wr_data_i <= val;
    @(posedge clk_i);
    if (idx == idea_pkg::IdxKeyUpper) key_hi_q = val;
    else key_lo_q = val;
  endtask

  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    drain();
    write_key(idea_pkg::IdxKeyUpper, hi);
    write_key(idea_pkg::IdxKeyLower, lo);
    wr_en_i <= 1'b0;
  endtask

  // field extremes and zero words under the reset key, then the pattern and all-ones keys
  task automatic test_directed;
    logic [63:0] pats[8];
    pats = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0001_0002_0003_0004,
             64'h0000_FFFF_0000_FFFF, 64'h8000_0000_0000_0001, 64'hFFFF_0000_FFFF_0000,
             64'h0001_0001_0001_0001, 64'h5555_AAAA_5555_AAAA};
    for (int i = 0; i < 8; i++) begin
      send_block(OpEncrypt, pats[i]);
      send_block(OpDecrypt, pats[i]);
    end
    load_key(64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008);
    send_block(OpEncrypt, 64'h0000_0001_0002_0003);
    send_block(OpDecrypt, 64'h11FB_ED2B_0198_6DE5);
    load_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(OpEncrypt, 64'h0);
    send_block(OpDecrypt, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // random blocks and ops, keys changed between bursts
  task automatic test_random(input int unsigned gap_pct, input int unsigned n);
    send_gap_pct = gap_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) load_key({$urandom, $urandom}, {$urandom, $urandom});
      send_block(1'($urandom_range(1)), {$urandom, $urandom});
    end
  endtask

  // stimulus
  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = OpEncrypt;
    block_in_i = '0;
    wr_en_i = 1'b0;
    wr_idx_i = idea_pkg::IdxKeyUpper;
    wr_data_i = '0;
    key_hi_q = '0;
    key_lo_q = '0;
    send_gap_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(18, 350);
    test_random(61, 300);
    test_random(0, 350);
    drain();
    $display("covered %0d requests, %0d results checked, encrypt and decrypt",
             block_cnt, checked_cnt);
    $display("keys: reset zero, all ones, directed pattern and random");
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (block_cnt == checked_cnt) begin
        $error("unexpected result block_out %h", block_out_o);
        fail_cnt++;
      end else begin
        if (block_out_o !== expected_blocks[checked_cnt % ExpDepth]) begin
          $error("block_out expected %h actual %h",
                 expected_blocks[checked_cnt % ExpDepth], block_out_o);
          fail_cnt++;
        end
        checked_cnt++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/idea_pkg.sv
hw/rtl/idea_round.sv
hw/rtl/idea_block_cipher.sv
verif/testbench.sv
